@@ rtl/sha256_byte_stream_hasher_unit_defines.svh @@
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Antecedent and consequent hold in the same cycle.
`define SHB_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SHB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/shb_pkg.sv @@
`default_nettype none

package shb_pkg;

    // Eight 32-bit words: hash state, working variables or digest.
    typedef logic [7:0][31:0] work_t;

    // One 64-byte block, first byte in the top bits.
    typedef logic [511:0] block_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_DONE
    } state_t;

    // Where the sequencer goes after a compression.
    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_DONE
    } ret_t;

    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_LAST   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam work_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/shb_round.sv @@
`default_nettype none

// One SHA-256 round plus one message schedule step.
module shb_round (
    input  wire shb_pkg::work_t  work,
    input  wire shb_pkg::block_t window,
    input  wire logic [31:0]     k,
    output shb_pkg::work_t       work_out,
    output logic [31:0]          w_new
);
    import shb_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sm0;
    logic [31:0] sm1;

    // Word j of the 16-word window sits at bits 511-32j downward.
    assign w0  = window[511:480];
    assign w1  = window[479:448];
    assign w9  = window[223:192];
    assign w14 = window[63:32];

    assign big_s1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    assign big_s0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    assign ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
    assign maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    assign t1     = work[7] + big_s1 + ch + k + w0;
    assign t2     = big_s0 + maj;

    assign sm0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign sm1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = sm1 + w9 + sm0 + w0;

    always_comb
    begin
        work_out[7] = work[6];
        work_out[6] = work[5];
        work_out[5] = work[4];
        work_out[4] = work[3] + t1;
        work_out[3] = work[2];
        work_out[2] = work[1];
        work_out[1] = work[0];
        work_out[0] = t1 + t2;
    end

endmodule

`default_nettype wire

@@ rtl/sha256_byte_stream_hasher_unit.sv @@
`default_nettype none

// SHA-256 hasher fed one message byte per input transfer. The action code in s_tuser
// says whether the byte is plain data, the final byte, or a finish with no byte. A byte
// that completes a 64-byte block starts a compression: 64 rounds on one shared round
// unit at one round per cycle, then a fold of the result into the hash state. A finish
// writes the padding one byte per cycle into the block, from the fill point to the block
// end, runs one or two such compressions, and then moves the digest into an output
// buffer. The digest leaves as eight output transfers, most significant word first, with
// tlast on the eighth. The output buffer lets the next message stream in while the
// digest is still being taken; a second finish waits only if the previous digest has not
// fully drained. s_tready is low while the round unit or the padding sequencer is busy.
// The bit length wraps modulo 2^64, and an unused action code is accepted and ignored.
module sha256_byte_stream_hasher_unit (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,   // data_byte [7:0]
    input  wire  logic [1:0]  s_tuser,   // action [1:0]
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [39:0]       m_tdata,   // digest_word [31:0], word_index [34:32], zeros
    output logic              m_tlast    // last_word
);
    import shb_pkg::*;

    `include "sha256_byte_stream_hasher_unit_defines.svh"

    state_t      state_reg, state_next;
    ret_t        ret_reg, ret_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] len_reg, len_next;
    logic        sent80_reg, sent80_next;
    logic        len_ok_reg, len_ok_next;
    logic        out_busy_reg, out_busy_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    block_t      blk_reg, blk_next;
    work_t       hash_reg, hash_next;
    work_t       work_reg, work_next;
    work_t       digest_reg, digest_next;

    work_t       round_work;
    logic [31:0] round_w;
    logic [63:0] bit_len;
    logic [7:0]  pad_byte;
    logic        in_xfer;
    logic        is_byte;
    logic        blk_full;

    shb_round u_round (
        .work     (work_reg),
        .window   (blk_reg),
        .k        (round_k(round_reg)),
        .work_out (round_work),
        .w_new    (round_w)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign is_byte  = (s_tuser == ACT_DATA) || (s_tuser == ACT_LAST);
    assign blk_full = (fill_reg == LAST_POS);
    assign bit_len  = {len_reg, 3'b000};

    // Padding byte for the current fill position: the marker byte first, then zeros,
    // with the big-endian bit length in the last eight positions of the final block.
    always_comb
    begin
        if (!sent80_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (len_ok_reg && (fill_reg >= LEN_POS))
        begin
            pad_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (is_byte && blk_full)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if ((s_tuser == ACT_LAST) || (s_tuser == ACT_FINISH))
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                case (ret_reg)
                    RET_PAD:  state_next = ST_PAD;
                    RET_DONE: state_next = ST_DONE;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                if (blk_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_DONE:
            begin
                if (!out_busy_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output buffer updates.
    always_comb
    begin
        ret_next      = ret_reg;
        round_next    = round_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        sent80_next   = sent80_reg;
        len_ok_next   = len_ok_reg;
        out_busy_next = out_busy_reg;
        out_idx_next  = out_idx_reg;
        blk_next      = blk_reg;
        hash_next     = hash_reg;
        work_next     = work_reg;
        digest_next   = digest_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && is_byte)
                begin
                    blk_next  = {blk_reg[503:0], s_tdata};
                    fill_next = fill_reg + 6'd1;
                    len_next  = len_reg + 61'd1;
                    if (blk_full)
                    begin
                        work_next  = hash_reg;
                        round_next = 6'd0;
                        ret_next   = (s_tuser == ACT_LAST) ? RET_PAD : RET_IDLE;
                    end
                end
            end
            ST_ROUND:
            begin
                work_next  = round_work;
                blk_next   = {blk_reg[479:0], round_w};
                round_next = round_reg + 6'd1;
            end
            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
            end
            ST_PAD:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (!sent80_reg)
                begin
                    sent80_next = 1'b1;
                    len_ok_next = (fill_reg < LEN_POS);
                end
                if (blk_full)
                begin
                    work_next  = hash_reg;
                    round_next = 6'd0;
                    if (sent80_reg && len_ok_reg)
                    begin
                        ret_next = RET_DONE;
                    end
                    else
                    begin
                        // The marker landed too late for the length: one more block.
                        ret_next    = RET_PAD;
                        len_ok_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_busy_reg)
                begin
                    digest_next   = hash_reg;
                    hash_next     = H_INIT;
                    len_next      = '0;
                    fill_next     = '0;
                    sent80_next   = 1'b0;
                    len_ok_next   = 1'b0;
                    out_busy_next = 1'b1;
                    out_idx_next  = '0;
                end
            end
            default:
            begin
            end
        endcase

        // The output side drains independently; a new digest loads only when idle.
        if (out_busy_reg && m_tready)
        begin
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == LAST_WORD_IDX)
            begin
                out_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_reg      <= RET_IDLE;
            round_reg    <= '0;
            fill_reg     <= '0;
            len_reg      <= '0;
            sent80_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            out_busy_reg <= 1'b0;
            out_idx_reg  <= '0;
            hash_reg     <= H_INIT;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            round_reg    <= round_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            sent80_reg   <= sent80_next;
            len_ok_reg   <= len_ok_next;
            out_busy_reg <= out_busy_next;
            out_idx_reg  <= out_idx_next;
            hash_reg     <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg    <= blk_next;
        work_reg   <= work_next;
        digest_reg <= digest_next;
    end

    assign m_tvalid = out_busy_reg;
    assign m_tdata  = {5'b00000, out_idx_reg, digest_reg[out_idx_reg]};
    assign m_tlast  = (out_idx_reg == LAST_WORD_IDX);

    `SHB_ASSERT_NEXT(a_digest_ends, m_tvalid && m_tready && m_tlast, !m_tvalid,
        "digest did not end after its last word")
    `SHB_ASSERT_NEXT(a_round_steps, (state_reg == ST_ROUND) && (round_reg != LAST_ROUND),
        (state_reg == ST_ROUND) && (round_reg == $past(round_reg) + 6'd1),
        "round counter skipped or left early")
    `SHB_ASSERT_NEXT(a_full_block_compresses, in_xfer && is_byte && blk_full,
        state_reg == ST_ROUND, "full block did not start a compression")
    `SHB_ASSERT_SAME(a_fill_tracks_len, state_reg == ST_IDLE, fill_reg == len_reg[5:0],
        "block fill point lost track of the byte count")

endmodule

`default_nettype wire
